>>> hw/rtl/pts_pkg.sv
package pts_pkg;

   localparam int NUM_TASKS      = 8;
   localparam int COUNT_WIDTH    = 16;
   localparam int MAX_RESULTS    = 8;

   localparam int OP_W           = 2;
   localparam int SLOT_IN_W      = 3;
   localparam int PERIOD_W       = 16;
   localparam int INDEX_W        = 3;
   localparam int ACTIVE_COUNT_W = 4;

   localparam int SLOT_W         = $clog2(NUM_TASKS);
   localparam int CNT_W          = $clog2(NUM_TASKS + 1);
   localparam int EMIT_W         = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_EXEC   = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

   typedef struct packed {
      logic execute;    // apply tick, add, delete or empty exec, load one result
      logic scan_init;  // start the exec scan at slot 0
      logic scan_step;  // look at one slot, emit it if pending
   } pts_cmd_type;

   typedef struct packed {
      logic any_pending;
      logic hit;        // slot under the scan pointer is pending
      logic last_hit;   // and it is the final result of this exec
   } pts_stat_type;

endpackage

>>> hw/rtl/pts_ctrl.sv
module pts_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [pts_pkg::OP_W-1:0]    req_operation,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pts_pkg::pts_cmd_type        cmd,
   input  pts_pkg::pts_stat_type       st
);
   import pts_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_EXEC && st.any_pending) begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end else begin
                  cmd.execute  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (out_free) begin
               cmd.scan_step = 1'b1;
               if (st.hit) begin
                  rsp_valid_in = 1'b1;
                  if (st.last_hit) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> st.any_pending)
      else $error("exec scan running with nothing pending");

   a_execute_gives_word: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("single-word operation produced no result");

   a_exec_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_fire && req_operation == OP_EXEC && st.any_pending)
      |=> state_ff == S_SCAN)
      else $error("exec with pending slots did not start a scan");

endmodule

>>> hw/rtl/pts_dp.sv
module pts_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pts_pkg::OP_W-1:0]            req_operation,
   input  logic [pts_pkg::SLOT_IN_W-1:0]       req_slot,
   input  logic [pts_pkg::PERIOD_W-1:0]        req_period,
   input  pts_pkg::pts_cmd_type                cmd,
   output pts_pkg::pts_stat_type               st,
   output logic [pts_pkg::INDEX_W-1:0]         rsp_task_index,
   output logic                                rsp_task_valid,
   output logic                                rsp_status,
   output logic [pts_pkg::ACTIVE_COUNT_W-1:0]  rsp_active_count,
   output logic                                rsp_last
);
   import pts_pkg::*;

   logic [COUNT_WIDTH-1:0] remaining_ff [NUM_TASKS];
   logic [COUNT_WIDTH-1:0] remaining_in [NUM_TASKS];
   logic [COUNT_WIDTH-1:0] reload_ff    [NUM_TASKS];
   logic [COUNT_WIDTH-1:0] reload_in    [NUM_TASKS];
   logic [NUM_TASKS-1:0]   pending_ff, pending_in;
   logic [NUM_TASKS-1:0]   active_ff, active_in;
   logic [CNT_W-1:0]       active_cnt_ff, active_cnt_in;
   logic [SLOT_W-1:0]      ptr_ff, ptr_in;
   logic [EMIT_W-1:0]      emitted_ff, emitted_in;

   logic [INDEX_W-1:0]        task_index_ff, task_index_in;
   logic                      task_valid_ff, task_valid_in;
   logic                      status_ff, status_in;
   logic [ACTIVE_COUNT_W-1:0] active_count_ff, active_count_in;
   logic                      last_ff, last_in;

   logic [SLOT_W-1:0]      slot_idx;
   logic                   slot_ok;
   logic [COUNT_WIDTH-1:0] period;
   logic [NUM_TASKS-1:0]   ready_vec;
   logic [NUM_TASKS-1:0]   above;
   logic                   del_miss;

   assign slot_idx  = SLOT_W'(req_slot);
   assign slot_ok   = 32'(req_slot) < NUM_TASKS;
   assign period    = COUNT_WIDTH'(req_period);
   assign ready_vec = active_ff & pending_ff;
   assign del_miss  = !(slot_ok && active_ff[slot_idx]);

   always_comb begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         above[i] = i > int'(ptr_ff);
      end
   end

   assign st.any_pending = |ready_vec;
   assign st.hit         = ready_vec[ptr_ff];
   assign st.last_hit    = ready_vec[ptr_ff] &&
                           (!(|(ready_vec & above)) ||
                            emitted_ff == EMIT_W'(MAX_RESULTS - 1));

   always_comb begin
      remaining_in    = remaining_ff;
      reload_in       = reload_ff;
      pending_in      = pending_ff;
      active_in       = active_ff;
      active_cnt_in   = active_cnt_ff;
      ptr_in          = ptr_ff;
      emitted_in      = emitted_ff;
      task_index_in   = task_index_ff;
      task_valid_in   = task_valid_ff;
      status_in       = status_ff;
      active_count_in = active_count_ff;
      last_in         = last_ff;

      if (cmd.execute) begin
         status_in = 1'b0;
         case (req_operation)
            OP_TICK: begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  if (active_ff[i] && remaining_ff[i] != '0) begin
                     // reaching zero: flag and reload
                     if (remaining_ff[i] == COUNT_WIDTH'(1)) begin
                        pending_in[i]   = 1'b1;
                        remaining_in[i] = reload_ff[i];
                     end else begin
                        remaining_in[i] = remaining_ff[i] - COUNT_WIDTH'(1);
                     end
                  end
               end
            end
            OP_ADD: begin
               if (slot_ok) begin
                  remaining_in[slot_idx] = period;
                  reload_in[slot_idx]    = period;
                  pending_in[slot_idx]   = 1'b0;
                  active_in[slot_idx]    = 1'b1;
                  if (!active_ff[slot_idx]) begin
                     active_cnt_in = active_cnt_ff + CNT_W'(1);
                  end
               end
            end
            OP_DELETE: begin
               status_in = del_miss;
               if (!del_miss) begin
                  active_in[slot_idx]  = 1'b0;
                  pending_in[slot_idx] = 1'b0;
                  active_cnt_in        = active_cnt_ff - CNT_W'(1);
               end
            end
            default: begin
               // exec with nothing pending: empty word only
            end
         endcase
         task_index_in   = '0;
         task_valid_in   = 1'b0;
         active_count_in = ACTIVE_COUNT_W'(active_cnt_in);
         last_in         = 1'b1;
      end

      if (cmd.scan_init) begin
         ptr_in     = '0;
         emitted_in = '0;
      end

      if (cmd.scan_step) begin
         ptr_in = ptr_ff + SLOT_W'(1);
         if (st.hit) begin
            pending_in[ptr_ff] = 1'b0;
            emitted_in         = emitted_ff + EMIT_W'(1);
            task_index_in      = INDEX_W'(ptr_ff);
            task_valid_in      = 1'b1;
            status_in          = 1'b0;
            active_count_in    = ACTIVE_COUNT_W'(active_cnt_ff);
            last_in            = st.last_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         active_ff     <= '0;
         active_cnt_ff <= '0;
         ptr_ff        <= '0;
         emitted_ff    <= '0;
      end else begin
         pending_ff    <= pending_in;
         active_ff     <= active_in;
         active_cnt_ff <= active_cnt_in;
         ptr_ff        <= ptr_in;
         emitted_ff    <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff    <= remaining_in;
      reload_ff       <= reload_in;
      task_index_ff   <= task_index_in;
      task_valid_ff   <= task_valid_in;
      status_ff       <= status_in;
      active_count_ff <= active_count_in;
      last_ff         <= last_in;
   end

   assign rsp_task_index   = task_index_ff;
   assign rsp_task_valid   = task_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_active_count = active_count_ff;
   assign rsp_last         = last_ff;

endmodule

>>> hw/rtl/periodic_task_slot_scheduler_unit.sv
// Periodic task slot scheduler: a table of task slots with period, down-counter,
// pending and active flags.
// Request channel (req_valid / req_stall): operation tick, exec, add or delete,
// with slot and period. Response channel (rsp_valid / rsp_stall): one word per
// result, rsp_last marks the final word of a request.
// Tick, add and delete: one word, shown the cycle after the request is taken; a
// tick steps every active non-zero counter. A new request is taken in the cycle
// the previous word leaves: one request per cycle while rsp_stall stays low.
// Exec: the request starts the scan, then the scan pointer visits one slot per
// cycle while the word channel is free, in ascending order up to the highest
// pending slot, each pending slot giving one word. With nothing pending exec
// gives a single empty word, shown the cycle after the request is taken.
// While rsp_stall is high the waiting word holds and the scan pauses; requests
// are stalled until the word is taken. Reset clears every slot's flags, no tasks
// active, and the block accepts requests from the first cycle after reset.
module periodic_task_slot_scheduler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pts_pkg::OP_W-1:0]            req_operation,
   input  logic [pts_pkg::SLOT_IN_W-1:0]       req_slot,
   input  logic [pts_pkg::PERIOD_W-1:0]        req_period,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pts_pkg::INDEX_W-1:0]         rsp_task_index,
   output logic                                rsp_task_valid,
   output logic                                rsp_status,
   output logic [pts_pkg::ACTIVE_COUNT_W-1:0]  rsp_active_count,
   output logic                                rsp_last
);
   import pts_pkg::*;

   pts_cmd_type  cmd;
   pts_stat_type st;

   pts_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .st            (st)
   );

   pts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_slot         (req_slot),
      .req_period       (req_period),
      .cmd              (cmd),
      .st               (st),
      .rsp_task_index   (rsp_task_index),
      .rsp_task_valid   (rsp_task_valid),
      .rsp_status       (rsp_status),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last)
   );

endmodule

>>> verif/slot_table_checker.sv
`timescale 1ns / 100ps

module slot_table_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [pts_pkg::OP_W-1:0]            req_operation,
   input  logic [pts_pkg::SLOT_IN_W-1:0]       req_slot,
   input  logic [pts_pkg::PERIOD_W-1:0]        req_period,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pts_pkg::INDEX_W-1:0]         rsp_task_index,
   input  logic                                rsp_task_valid,
   input  logic                                rsp_status,
   input  logic [pts_pkg::ACTIVE_COUNT_W-1:0]  rsp_active_count,
   input  logic                                rsp_last,
   output int                                  mismatch_count,
   output int                                  words_due
);
   import pts_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0]        task_index;
      logic                      task_valid;
      logic                      status;
      logic [ACTIVE_COUNT_W-1:0] active_count;
      logic                      last;
   } sched_word_type;

   sched_word_type         words_owed[$];
   logic [COUNT_WIDTH-1:0] countdown [NUM_TASKS];
   logic [COUNT_WIDTH-1:0] reload_value [NUM_TASKS];
   bit                     ready_flag [NUM_TASKS];
   bit                     in_use [NUM_TASKS];

   function automatic logic [ACTIVE_COUNT_W-1:0] slots_in_use();
      int n;
      n = 0;
      for (int i = 0; i < NUM_TASKS; i++)
         n += in_use[i] ? 1 : 0;
      return ACTIVE_COUNT_W'(n);
   endfunction

   function automatic sched_word_type make_word(int idx, bit valid, bit status, bit last);
      sched_word_type w;
      w.task_index   = INDEX_W'(idx);
      w.task_valid   = valid;
      w.status       = status;
      w.active_count = slots_in_use();
      w.last         = last;
      return w;
   endfunction

   task automatic advance_slot_table(input logic [OP_W-1:0] op,
                                     input logic [SLOT_IN_W-1:0] slot,
                                     input logic [PERIOD_W-1:0] period);
      int                     hits;
      logic [COUNT_WIDTH-1:0] per;
      per = period[COUNT_WIDTH-1:0];
      case (op)
         OP_TICK: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (in_use[i] && countdown[i] != '0) begin
                  countdown[i] = countdown[i] - 1'b1;
                  // fire and reload from the period
                  if (countdown[i] == '0) begin
                     ready_flag[i] = 1'b1;
                     countdown[i]  = reload_value[i];
                  end
               end
            end
            words_owed.push_back(make_word(0, 1'b0, 1'b0, 1'b1));
         end
         OP_EXEC: begin
            hits = 0;
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (in_use[i] && ready_flag[i] && hits < MAX_RESULTS) begin
                  ready_flag[i] = 1'b0;
                  words_owed.push_back(make_word(i, 1'b1, 1'b0, 1'b0));
                  hits++;
               end
            end
            if (hits == 0)
               words_owed.push_back(make_word(0, 1'b0, 1'b0, 1'b1));
            else
               words_owed[words_owed.size()-1].last = 1'b1;
         end
         OP_ADD: begin
            if (int'(slot) < NUM_TASKS) begin
               countdown[slot]    = per;
               reload_value[slot] = per;
               ready_flag[slot]   = 1'b0;
               in_use[slot]       = 1'b1;
            end
            words_owed.push_back(make_word(0, 1'b0, 1'b0, 1'b1));
         end
         OP_DELETE: begin
            if (int'(slot) < NUM_TASKS && in_use[slot]) begin
               in_use[slot]     = 1'b0;
               ready_flag[slot] = 1'b0;
               words_owed.push_back(make_word(0, 1'b0, 1'b0, 1'b1));
            end else begin
               words_owed.push_back(make_word(0, 1'b0, 1'b1, 1'b1));
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_word();
      sched_word_type want;
      sched_word_type got;
      got = '{rsp_task_index, rsp_task_valid, rsp_status, rsp_active_count, rsp_last};
      if (words_owed.size() == 0) begin
         if (mismatch_count < 10)
            $display("%0t: unexpected word index=%0d valid=%0b status=%0b count=%0d last=%0b",
                     $realtime, got.task_index, got.task_valid, got.status,
                     got.active_count, got.last);
         mismatch_count++;
      end else begin
         want = words_owed.pop_front();
         if (got !== want) begin
            if (mismatch_count < 10) begin
               $display("%0t: word mismatch", $realtime);
               $display("   expected index=%0d valid=%0b status=%0b count=%0d last=%0b",
                        want.task_index, want.task_valid, want.status,
                        want.active_count, want.last);
               $display("   actual   index=%0d valid=%0b status=%0b count=%0d last=%0b",
                        got.task_index, got.task_valid, got.status,
                        got.active_count, got.last);
            end
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         words_owed.delete();
         mismatch_count = 0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            countdown[i]    = '0;
            reload_value[i] = '0;
            ready_flag[i]   = 1'b0;
            in_use[i]       = 1'b0;
         end
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_word();
         if (req_valid && !req_stall)
            advance_slot_table(req_operation, req_slot, req_period);
      end
      words_due = words_owed.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import pts_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_operation = OP_TICK;
   logic [SLOT_IN_W-1:0]      req_slot = '0;
   logic [PERIOD_W-1:0]       req_period = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [INDEX_W-1:0]        rsp_task_index;
   logic                      rsp_task_valid;
   logic                      rsp_status;
   logic [ACTIVE_COUNT_W-1:0] rsp_active_count;
   logic                      rsp_last;

   int mismatch_count;
   int words_due;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit squeeze = 1'b0;
   int hold_left = 0;
   bit squeeze_seen = 1'b0;

   always #5 clock = ~clock;

   periodic_task_slot_scheduler_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_slot         (req_slot),
      .req_period       (req_period),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_task_index   (rsp_task_index),
      .rsp_task_valid   (rsp_task_valid),
      .rsp_status       (rsp_status),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last)
   );

   slot_table_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_slot         (req_slot),
      .req_period       (req_period),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_task_index   (rsp_task_index),
      .rsp_task_valid   (rsp_task_valid),
      .rsp_status       (rsp_status),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .words_due        (words_due)
   );

   // receiver: random stall, plus one long hold-off when squeeze rises
   always @(posedge clock) begin
      if (squeeze && !squeeze_seen)
         hold_left = 400;
      squeeze_seen = squeeze;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   task automatic offer(input logic [OP_W-1:0] op, input int slot, input int period);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot      <= SLOT_IN_W'(slot);
      req_period    <= PERIOD_W'(period);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_requests(input int count);
      int              pick;
      int              span;
      int              period;
      logic [OP_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45)
            op = OP_TICK;
         else if (pick < 65)
            op = OP_EXEC;
         else if (pick < 85)
            op = OP_ADD;
         else
            op = OP_DELETE;
         // mostly short periods so that slots fire between execs
         span = $urandom_range(9);
         if (span < 6)
            period = $urandom_range(6);
         else if (span < 8)
            period = $urandom_range(65535);
         else if (span == 8)
            period = 65535;
         else
            period = 0;
         offer(op, $urandom_range(7), period);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 31;
      receiver_idle_pct <= 70;

      offer(OP_ADD, 0, 1);
      offer(OP_ADD, 7, 65535);
      offer(OP_ADD, 3, 0);
      offer(OP_TICK, 0, 0);
      offer(OP_EXEC, 0, 0);
      offer(OP_EXEC, 0, 0);
      // reload an active slot in place
      offer(OP_ADD, 0, 2);
      offer(OP_TICK, 5, 65535);
      offer(OP_DELETE, 5, 0);
      offer(OP_DELETE, 3, 0);
      offer(OP_DELETE, 3, 0);
      for (int s = 0; s < NUM_TASKS; s++)
         offer(OP_ADD, s, 1);
      offer(OP_TICK, 0, 0);
      offer(OP_EXEC, 0, 0);
      offer(OP_DELETE, 7, 0);
      offer(OP_EXEC, 0, 0);
      random_requests(115);

      sender_idle_pct = 70;
      receiver_idle_pct <= 31;
      random_requests(115);

      sender_idle_pct = 0;
      receiver_idle_pct <= 0;
      squeeze <= 1'b1;
      random_requests(120);

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
